// File: src/dsc_pkg.sv
package dsc_pkg;

    localparam int ACC_FRAC = 24;
    localparam int TABLE_LEN = 24;
    localparam int REG_AXIS_OFFSET = 0;
    localparam int REG_DEAD_ZONE   = 1;

    // Rotation angle of each CORDIC step, degrees in Q24.
    function automatic logic [31:0] atan_q24(input int i);
        logic [31:0] r;
        unique case (i)
            0: r = 32'd754974720;
            1: r = 32'd445687602;
            2: r = 32'd235489088;
            3: r = 32'd119537938;
            4: r = 32'd60000934;
            5: r = 32'd30029717;
            6: r = 32'd15018523;
            7: r = 32'd7509720;
            8: r = 32'd3754917;
            9: r = 32'd1877466;
            10: r = 32'd938734;
            11: r = 32'd469367;
            12: r = 32'd234684;
            13: r = 32'd117342;
            14: r = 32'd58671;
            15: r = 32'd29335;
            16: r = 32'd14668;
            17: r = 32'd7334;
            18: r = 32'd3667;
            19: r = 32'd1833;
            20: r = 32'd917;
            21: r = 32'd458;
            22: r = 32'd229;
            23: r = 32'd115;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: src/dsc_axis.sv
// Scaled value and force contribution of one offset axis (combinational).
module dsc_axis (
    input  logic signed [16:0] v,
    input  logic        [14:0] dead_zone,
    output logic signed [7:0]  scaled,
    output logic        [7:0]  force_val
);
    logic [16:0] mag;
    logic [24:0] p127;
    logic [25:0] p255;
    logic [9:0]  q;
    logic [10:0] f;

    always_comb
    begin
        mag  = v[16] ? 17'(-v) : 17'(v);
        p127 = 25'(mag) * 25'd127;
        p255 = 26'(mag) * 26'd255 + 26'd16384;
        q    = p127[24:15];
        if (q > 10'd127)
        begin
            q = 10'd127;
        end
        scaled = v[16] ? 8'(-q[7:0]) : q[7:0];
        f = p255[25:15];
        if (mag <= 17'(dead_zone))
        begin
            force_val = 8'd0;
        end
        else
        begin
            force_val = (f > 11'd255) ? 8'd255 : f[7:0];
        end
    end
endmodule

// File: src/dsc_cordic.sv
// Pipelined vectoring CORDIC: one step per stage, advances on en.
module dsc_cordic #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [16:0] x_in,
    input  logic signed [16:0] y_in,
    output logic        [14:0] angle
);
    localparam int N  = (CORDIC_STAGES < dsc_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                             : dsc_pkg::TABLE_LEN;
    localparam int DW = 35;
    localparam int ZW = 36;
    localparam int SH = dsc_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] FULL = ZW'(64'sd360 <<< dsc_pkg::ACC_FRAC);
    localparam logic signed [ZW-1:0] HALF = ZW'(64'sd180 <<< dsc_pkg::ACC_FRAC);
    localparam logic [ZW-1:0] RND = ZW'(64'd1 << (SH - 1));
    localparam logic [ZW-1:0] UNITS_FULL = ZW'(64'd360 << ANGLE_FRAC_BITS);

    logic signed [DW-1:0] x_reg [0:N];
    logic signed [DW-1:0] y_reg [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic                 zero_reg [0:N];
    logic signed [ZW-1:0] zw_reg;
    logic                 zero_w_reg;
    logic [ZW-1:0]        units_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == 17'sd0);
            if (x_in[16])
            begin
                x_reg[0] <= DW'(-x_in) <<< 14;
                y_reg[0] <= DW'(-y_in) <<< 14;
                z_reg[0] <= HALF;
            end
            else
            begin
                x_reg[0] <= DW'(x_in) <<< 14;
                y_reg[0] <= DW'(y_in) <<< 14;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][DW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZW'(dsc_pkg::atan_q24(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZW'(dsc_pkg::atan_q24(i));
                end
            end
        end
    end

    // Wrap into [0, 360) degrees; the sum stays within one turn either side.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_w_reg <= zero_reg[N];
            if (z_reg[N] < 0)
            begin
                zw_reg <= z_reg[N] + FULL;
            end
            else if (z_reg[N] >= FULL)
            begin
                zw_reg <= z_reg[N] - FULL;
            end
            else
            begin
                zw_reg <= z_reg[N];
            end
        end
    end

    always_comb
    begin
        units_next = (ZW'(zw_reg) + RND) >> SH;
        if (units_next >= UNITS_FULL)
        begin
            units_next = units_next - UNITS_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle <= zero_w_reg ? 15'd0 : units_next[14:0];
        end
    end
endmodule

// File: src/dual_stick_conditioner_top.sv
// Dual analogue stick conditioner.
// Each item on the s_axis channel carries one sample of both sticks; the
// block returns one item per sample on m_axis holding the four scaled axes,
// the two stick forces and the two stick angles. The configuration port
// writes axis_offset (index 0) and dead_zone (index 1); write only while no
// item is in flight.
// Between acceptance and the result lie the offset stage, the CORDIC stages
// (24 stages at most are used), the wrap and the angle register. Throughput is
// one item per cycle unless m_axis stalls, as the datapath is one pipeline.
// A stall on m_axis freezes every stage at once: while the last stage holds an
// item that is not taken, s_axis_tready follows m_axis_tready and no stage
// moves, so empty stages are not filled during the stall. Reset clears all
// valid bits and loads the registers with their defaults (offset 100, dead
// zone 1638).
module dual_stick_conditioner_top #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // left_x_raw, left_y_raw, right_x_raw, right_y_raw from bit 0 upwards
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_x_scaled, left_y_scaled, right_x_scaled, right_y_scaled,
    // left_force, right_force, left_angle, right_angle, then two zero bits
    output logic [79:0] m_axis_tdata
);
    localparam int N = (CORDIC_STAGES < dsc_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                            : dsc_pkg::TABLE_LEN;
    localparam int DEPTH = N + 4;

    logic signed [10:0] axis_offset_reg;
    logic        [14:0] dead_zone_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic               en;

    logic signed [16:0] ax_reg [4];
    logic signed [7:0]  sc_next [4];
    logic        [7:0]  fo_next [4];
    logic signed [7:0]  sc_reg [DEPTH-1:1][4];
    logic        [7:0]  lf_reg [DEPTH-1:1];
    logic        [7:0]  rf_reg [DEPTH-1:1];
    logic        [14:0] ang [2];

    // The pipeline advances unless its last stage holds an item not taken.
    assign en            = !valid_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_offset_reg <= 11'sd100;
            dead_zone_reg   <= 15'd1638;
            valid_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == 1'(dsc_pkg::REG_AXIS_OFFSET))
                begin
                    axis_offset_reg <= cfg_data[10:0];
                end
                else
                begin
                    dead_zone_reg <= cfg_data;
                end
            end
            if (en)
            begin
                valid_reg <= {valid_reg[DEPTH-2:0], s_axis_tvalid};
            end
        end
    end

    // Stage 0: apply offset, negate the Y axes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg[0] <= 17'(signed'(s_axis_tdata[15:0])) + 17'(axis_offset_reg);
            ax_reg[1] <= -(17'(signed'(s_axis_tdata[31:16])) + 17'(axis_offset_reg));
            ax_reg[2] <= 17'(signed'(s_axis_tdata[47:32])) + 17'(axis_offset_reg);
            ax_reg[3] <= -(17'(signed'(s_axis_tdata[63:48])) + 17'(axis_offset_reg));
        end
    end

    for (genvar a = 0; a < 4; a++)
    begin : g_axis
        dsc_axis u_axis (
            .v         (ax_reg[a]),
            .dead_zone (dead_zone_reg),
            .scaled    (sc_next[a]),
            .force_val (fo_next[a])
        );
    end

    // Side line carrying axis results alongside the CORDIC.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg[1] <= sc_next;
            lf_reg[1] <= (fo_next[0] > fo_next[1]) ? fo_next[0] : fo_next[1];
            rf_reg[1] <= (fo_next[2] > fo_next[3]) ? fo_next[2] : fo_next[3];
            for (int k = 2; k < DEPTH; k++)
            begin
                sc_reg[k] <= sc_reg[k-1];
                lf_reg[k] <= lf_reg[k-1];
                rf_reg[k] <= rf_reg[k-1];
            end
        end
    end

    dsc_cordic #(
        .CORDIC_STAGES   (CORDIC_STAGES),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic_left (
        .clk   (clk),
        .en    (en),
        .x_in  (ax_reg[0]),
        .y_in  (ax_reg[1]),
        .angle (ang[0])
    );

    dsc_cordic #(
        .CORDIC_STAGES   (CORDIC_STAGES),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic_right (
        .clk   (clk),
        .en    (en),
        .x_in  (ax_reg[2]),
        .y_in  (ax_reg[3]),
        .angle (ang[1])
    );

    assign m_axis_tdata = {2'b00, ang[1], ang[0], rf_reg[DEPTH-1], lf_reg[DEPTH-1],
                           sc_reg[DEPTH-1][3], sc_reg[DEPTH-1][2],
                           sc_reg[DEPTH-1][1], sc_reg[DEPTH-1][0]};
endmodule
